[design/wav_pkg.sv]
// ----------------------------------------------------------------------------
// WAV parser package
// Shared types, tag constants and the command word between front and back.
// ----------------------------------------------------------------------------
package wav_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [27:0] TOTAL_MAX      = 28'hFFFFFFF;
  localparam logic [27:0] MIN_FILE_BYTES = 28'd44;
  localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

  localparam logic [31:0] RATE_RESET     = 32'd16000;
  localparam logic [26:0] MAX_BYTES_RESET = 27'd100663296;

  localparam int CMD_DEPTH_DEF = 4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_LONG     = 3'd2;
  localparam logic [2:0] ST_TAGS     = 3'd3;
  localparam logic [2:0] ST_FORMAT   = 3'd4;
  localparam logic [2:0] ST_NOSAMPLE = 3'd5;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic CFG_EXPECTED_RATE  = 1'b0;
  localparam logic CFG_MAX_FILE_BYTES = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic               item_kind;
    logic signed [15:0] sample_value;
    logic [2:0]         status_code;
    logic               run_end;
  } out_item_t;

  // Work handed from the parser to the result stage.
  typedef struct packed {
    logic        has_sample;
    logic [15:0] sample;
    logic        has_status;
    logic [2:0]  status;
  } cmd_t;

endpackage

[design/wav_pcm16_stream_parser.sv]
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser
// Parses a RIFF/WAVE byte stream into Q1.15 samples and an end-of-file status.
// ----------------------------------------------------------------------------
// channel  direction  handshake        payload
// in_      input      push / full      data_byte, final_byte
// out_     output     empty / pop      item_kind, sample_value, status_code, run_end
// cfg_     input      valid / ready    index (0 rate, 1 max bytes), data
//
// One byte per cycle is accepted while the queue is not full; the parser updates
// its state in that cycle and places a command in a queue of CmdDepth entries.
// A byte that yields a sample and a status takes two output pops. full rises
// only when that queue is full. Reset is synchronous; cfg_ready is always high.
module wav_pcm16_stream_parser #(
  parameter int CmdDepth = wav_pkg::CMD_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  wav_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output wav_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0]   rate_r;
  logic [26:0]   maxb_r;
  logic          accept;
  wav_pkg::cmd_t fcmd, qcmd;
  logic          q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= wav_pkg::RATE_RESET;
      maxb_r <= wav_pkg::MAX_BYTES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wav_pkg::CFG_EXPECTED_RATE:  rate_r <= cfg_data;
        wav_pkg::CFG_MAX_FILE_BYTES: maxb_r <= cfg_data[26:0];
        default: ;
      endcase
    end
  end

  wav_front u_front (
    .clk(clk), .rst_n(rst_n), .byte_valid(accept), .byte_in(in_item),
    .expected_rate(rate_r), .max_file_bytes(maxb_r), .cmd(fcmd)
  );

  wav_cmd_fifo #(.Depth(CmdDepth)) u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(accept), .wr_data(fcmd), .full(full),
    .rd_en(q_pop), .rd_data(qcmd), .empty(q_empty)
  );

  wav_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_empty(q_empty), .cmd(qcmd), .cmd_pop(q_pop),
    .out_item(out_item), .out_empty(empty), .out_pop(pop)
  );

endmodule

[design/wav_front.sv]
// ----------------------------------------------------------------------------
// WAV parser front
// Walks the RIFF structure byte by byte and turns each byte into a command.
// ----------------------------------------------------------------------------
module wav_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  wav_pkg::in_item_t byte_in,
  input  logic [31:0]       expected_rate,
  input  logic [26:0]       max_file_bytes,
  output wav_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_CHUNK  = 6'b000010,
    PH_FMT    = 6'b000100,
    PH_SKIP   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [27:0] total_r, total_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [32:0] left_r, left_nxt;
  logic [15:0] fcode_r, fcode_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        fseen_r, fseen_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        etag_r, etag_nxt;
  logic        efmt_r, efmt_nxt;
  logic        any_r, any_nxt;

  logic [7:0]  b;
  logic [31:0] tag_sh;
  logic [31:0] clen_w;
  logic [32:0] padded;
  logic [32:0] fmt_rest;
  logic [32:0] left_dec;

  always_comb begin
    b        = byte_in.data_byte;
    tag_sh   = {tag_r[23:0], b};
    clen_w   = {b, clen_r[31:8]};
    padded   = {1'b0, clen_w} + {32'd0, clen_w[0]};
    fmt_rest = {1'b0, clen_r} - {1'b0, wav_pkg::FMT_BODY_BYTES} + {32'd0, clen_r[0]};
    left_dec = left_r - 33'd1;

    phase_nxt = phase_r; idx_nxt = idx_r; tag_nxt = tag_r; clen_nxt = clen_r;
    left_nxt = left_r; fcode_nxt = fcode_r; chan_nxt = chan_r; rate_nxt = rate_r;
    bits_nxt = bits_r; fseen_nxt = fseen_r; low_nxt = low_r; etag_nxt = etag_r;
    efmt_nxt = efmt_r; any_nxt = any_r;
    total_nxt = (total_r < wav_pkg::TOTAL_MAX) ? total_r + 28'd1 : total_r;
    cmd = '0;

    unique case (phase_r)
      PH_HEADER: begin
        tag_nxt = tag_sh;
        if (idx_r == 5'd3 && tag_sh != wav_pkg::TAG_RIFF) begin
          etag_nxt = 1'b1; phase_nxt = PH_DONE;
        end else if (idx_r == 5'd11) begin
          if (tag_sh != wav_pkg::TAG_WAVE) begin
            etag_nxt = 1'b1; phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_CHUNK; idx_nxt = '0;
          end
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      PH_CHUNK: begin
        // The length arrives low byte first, so shift it in from the top.
        if (idx_r < 5'd4) tag_nxt = tag_sh;
        else clen_nxt = clen_w;
        if (idx_r >= 5'd7) begin
          idx_nxt = '0;
          if (tag_r == wav_pkg::TAG_FMT) begin
            if (clen_w < wav_pkg::FMT_BODY_BYTES) begin
              efmt_nxt = 1'b1; phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_FMT;
            end
          end else if (tag_r == wav_pkg::TAG_DATA && fseen_r) begin
            if (fcode_r != 16'd1 || chan_r != 16'd1 || rate_r != expected_rate ||
                bits_r != 16'd16) begin
              efmt_nxt = 1'b1; phase_nxt = PH_DONE;
            end else if (clen_w < 32'd2) begin
              phase_nxt = PH_DONE;
            end else begin
              left_nxt = {1'b0, clen_w}; phase_nxt = PH_DATA;
            end
          end else begin
            if (padded == 33'd0) begin
              phase_nxt = PH_CHUNK;
            end else begin
              left_nxt = padded;
              phase_nxt = PH_SKIP;
            end
          end
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      PH_FMT: begin
        unique case (idx_r)
          5'd0:  fcode_nxt = {8'd0, b};
          5'd1:  fcode_nxt = {b, fcode_r[7:0]};
          5'd2:  chan_nxt = {8'd0, b};
          5'd3:  chan_nxt = {b, chan_r[7:0]};
          5'd4:  rate_nxt = {24'd0, b};
          5'd5:  rate_nxt = {16'd0, b, rate_r[7:0]};
          5'd6:  rate_nxt = {8'd0, b, rate_r[15:0]};
          5'd7:  rate_nxt = {b, rate_r[23:0]};
          5'd14: bits_nxt = {8'd0, b};
          5'd15: bits_nxt = {b, bits_r[7:0]};
          default: ;
        endcase
        if (idx_r >= 5'd15) begin
          fseen_nxt = 1'b1; idx_nxt = '0;
          if (fmt_rest == 33'd0) begin
            phase_nxt = PH_CHUNK;
          end else begin
            left_nxt = fmt_rest; phase_nxt = PH_SKIP;
          end
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      PH_SKIP: begin
        left_nxt = left_dec;
        if (left_dec == 33'd0) begin
          phase_nxt = PH_CHUNK; idx_nxt = '0;
        end
      end
      PH_DATA: begin
        left_nxt = left_dec;
        if (!idx_r[0]) begin
          low_nxt = b; idx_nxt = 5'd1;
        end else begin
          cmd.has_sample = 1'b1;
          cmd.sample = {b, low_r};
          any_nxt = 1'b1; idx_nxt = '0;
          if (left_dec < 33'd2) phase_nxt = PH_DONE;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    if (byte_in.final_byte) begin
      cmd.has_status = 1'b1;
      priority if (total_nxt < wav_pkg::MIN_FILE_BYTES) cmd.status = wav_pkg::ST_SHORT;
      else if (total_nxt > {1'b0, max_file_bytes}) cmd.status = wav_pkg::ST_LONG;
      else if (etag_nxt) cmd.status = wav_pkg::ST_TAGS;
      else if (efmt_nxt) cmd.status = wav_pkg::ST_FORMAT;
      else if (!any_nxt) cmd.status = wav_pkg::ST_NOSAMPLE;
      else cmd.status = wav_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; total_r <= '0; idx_r <= '0; tag_r <= '0; clen_r <= '0;
      left_r <= '0; fcode_r <= '0; chan_r <= '0; rate_r <= '0; bits_r <= '0;
      fseen_r <= 1'b0; low_r <= '0; etag_r <= 1'b0; efmt_r <= 1'b0; any_r <= 1'b0;
    end else if (byte_valid) begin
      if (byte_in.final_byte) begin
        phase_r <= PH_HEADER; total_r <= '0; idx_r <= '0; tag_r <= '0;
        clen_r <= '0; left_r <= '0; fcode_r <= '0; chan_r <= '0; rate_r <= '0;
        bits_r <= '0; fseen_r <= 1'b0; low_r <= '0; etag_r <= 1'b0;
        efmt_r <= 1'b0; any_r <= 1'b0;
      end else begin
        phase_r <= phase_nxt; total_r <= total_nxt; idx_r <= idx_nxt;
        tag_r <= tag_nxt; clen_r <= clen_nxt; left_r <= left_nxt;
        fcode_r <= fcode_nxt; chan_r <= chan_nxt; rate_r <= rate_nxt;
        bits_r <= bits_nxt; fseen_r <= fseen_nxt; low_r <= low_nxt;
        etag_r <= etag_nxt; efmt_r <= efmt_nxt; any_r <= any_nxt;
      end
    end
  end

endmodule

[design/wav_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// WAV parser command queue
// Short FIFO between the parser and the result stage.
// ----------------------------------------------------------------------------
module wav_cmd_fifo #(
  parameter int Depth = wav_pkg::CMD_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  wav_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output wav_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  wav_pkg::cmd_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = (cnt_r == (AW+1)'(Depth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + AW'(1);
      if (rd_en) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

[design/wav_back.sv]
// ----------------------------------------------------------------------------
// WAV parser back
// Expands each command into zero, one or two result items.
// ----------------------------------------------------------------------------
module wav_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  wav_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output wav_pkg::out_item_t out_item,
  output logic               out_empty,
  input  logic               out_pop
);

  logic sent_r; // sample of the head command already delivered

  logic need_sample;

  always_comb begin
    need_sample = cmd.has_sample && !sent_r;
    out_empty   = cmd_empty || (!need_sample && !cmd.has_status);
    out_item    = '0;
    if (need_sample) begin
      out_item.item_kind    = wav_pkg::KIND_SAMPLE;
      out_item.sample_value = cmd.sample;
      out_item.run_end      = !cmd.has_status;
    end else begin
      out_item.item_kind   = wav_pkg::KIND_STATUS;
      out_item.status_code = cmd.status;
      out_item.run_end     = 1'b1;
    end
    // Empty commands retire on their own; otherwise the last item retires.
    cmd_pop = !cmd_empty && ((!need_sample && !cmd.has_status) ||
              (out_pop && out_item.run_end));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r <= 1'b0;
    end else if (cmd_pop) begin
      sent_r <= 1'b0;
    end else if (!out_empty && out_pop && need_sample) begin
      sent_r <= 1'b1;
    end
  end

endmodule

[sim/wav_stream_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WAV stream checker
// Watches the byte, result and register channels of the WAV parser, keeps its
// own copy of the parse state and compares every popped result with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module wav_stream_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  wav_pkg::in_item_t  in_item,
  input  logic               empty,
  input  logic               pop,
  input  wav_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef enum logic [5:0] {
    P_HEADER = 6'b000001,
    P_CHUNK  = 6'b000010,
    P_FMT    = 6'b000100,
    P_SKIP   = 6'b001000,
    P_DATA   = 6'b010000,
    P_DONE   = 6'b100000
  } parse_phase_t;

  logic [31:0]  rate_reg;
  logic [26:0]  max_bytes_reg;

  logic [27:0]  byte_total;
  parse_phase_t phase;
  logic [4:0]   field_idx;
  logic [31:0]  tag_word;
  logic [31:0]  chunk_len;
  logic [32:0]  bytes_left;
  logic [15:0]  fmt_code;
  logic [15:0]  chan_count;
  logic [31:0]  fmt_rate;
  logic [15:0]  fmt_bits;
  logic         fmt_seen;
  logic [7:0]   low_hold;
  logic         err_tags;
  logic         err_format;
  logic         any_sample;

  wav_pkg::out_item_t expected_q[$];

  assign pending = expected_q.size();

  function automatic void add_expected(wav_pkg::out_item_t item);
    expected_q = {expected_q, item};
  endfunction

  function automatic void clear_parse();
    byte_total = '0; phase = P_HEADER; field_idx = '0; tag_word = '0;
    chunk_len = '0; bytes_left = '0; fmt_code = '0; chan_count = '0;
    fmt_rate = '0; fmt_bits = '0; fmt_seen = 1'b0; low_hold = '0;
    err_tags = 1'b0; err_format = 1'b0; any_sample = 1'b0;
  endfunction

  function automatic void skip_bytes(logic [32:0] n);
    field_idx = '0;
    if (n == 0) begin
      phase = P_CHUNK;
    end else begin
      bytes_left = n;
      phase = P_SKIP;
    end
  endfunction

  function automatic void decide_chunk();
    field_idx = '0;
    if (tag_word == wav_pkg::TAG_FMT) begin
      if (chunk_len < wav_pkg::FMT_BODY_BYTES) begin
        err_format = 1'b1;
        phase = P_DONE;
      end else begin
        phase = P_FMT;
      end
    end else if (tag_word == wav_pkg::TAG_DATA && fmt_seen) begin
      if (fmt_code != 16'd1 || chan_count != 16'd1 || fmt_rate != rate_reg ||
          fmt_bits != 16'd16) begin
        err_format = 1'b1;
        phase = P_DONE;
      end else if (chunk_len < 2) begin
        phase = P_DONE;
      end else begin
        bytes_left = {1'b0, chunk_len};
        phase = P_DATA;
      end
    end else begin
      skip_bytes({1'b0, chunk_len} + chunk_len[0]);
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic fin);
    wav_pkg::out_item_t r;
    if (byte_total < wav_pkg::TOTAL_MAX) byte_total++;
    unique case (phase)
      P_HEADER: begin
        tag_word = {tag_word[23:0], b};
        if (field_idx == 3 && tag_word != wav_pkg::TAG_RIFF) begin
          err_tags = 1'b1;
          phase = P_DONE;
        end else if (field_idx == 11) begin
          if (tag_word != wav_pkg::TAG_WAVE) begin
            err_tags = 1'b1;
            phase = P_DONE;
          end else begin
            phase = P_CHUNK;
            field_idx = '0;
          end
        end else begin
          field_idx++;
        end
      end
      P_CHUNK: begin
        if (field_idx < 4) begin
          tag_word = {tag_word[23:0], b};
        end else begin
          if (field_idx == 4) chunk_len = '0;
          chunk_len |= 32'(b) << ((field_idx - 5'd4) * 8);
        end
        if (field_idx >= 7) decide_chunk();
        else field_idx++;
      end
      P_FMT: begin
        unique case (field_idx)
          5'd0:  fmt_code = {8'h00, b};
          5'd1:  fmt_code[15:8] = b;
          5'd2:  chan_count = {8'h00, b};
          5'd3:  chan_count[15:8] = b;
          5'd4:  fmt_rate = {24'h0, b};
          5'd5:  fmt_rate[15:8] = b;
          5'd6:  fmt_rate[23:16] = b;
          5'd7:  fmt_rate[31:24] = b;
          5'd14: fmt_bits = {8'h00, b};
          5'd15: fmt_bits[15:8] = b;
          default: ;
        endcase
        if (field_idx >= 15) begin
          fmt_seen = 1'b1;
          skip_bytes({1'b0, chunk_len} - 33'd16 + chunk_len[0]);
        end else begin
          field_idx++;
        end
      end
      P_SKIP: begin
        bytes_left--;
        if (bytes_left == 0) begin
          phase = P_CHUNK;
          field_idx = '0;
        end
      end
      P_DATA: begin
        bytes_left--;
        if (!field_idx[0]) begin
          low_hold = b;
          field_idx = 5'd1;
        end else begin
          r = '0;
          r.item_kind = wav_pkg::KIND_SAMPLE;
          r.sample_value = {b, low_hold};
          r.status_code = wav_pkg::ST_OK;
          r.run_end = !fin;
          add_expected(r);
          any_sample = 1'b1;
          field_idx = '0;
          if (bytes_left < 2) phase = P_DONE;
        end
      end
      default: ;
    endcase
    if (fin) begin
      r = '0;
      r.item_kind = wav_pkg::KIND_STATUS;
      r.run_end = 1'b1;
      if (byte_total < wav_pkg::MIN_FILE_BYTES) r.status_code = wav_pkg::ST_SHORT;
      else if (byte_total > {1'b0, max_bytes_reg}) r.status_code = wav_pkg::ST_LONG;
      else if (err_tags) r.status_code = wav_pkg::ST_TAGS;
      else if (err_format) r.status_code = wav_pkg::ST_FORMAT;
      else if (!any_sample) r.status_code = wav_pkg::ST_NOSAMPLE;
      else r.status_code = wav_pkg::ST_OK;
      add_expected(r);
      clear_parse();
    end
  endfunction

  always @(posedge clk) begin
    wav_pkg::out_item_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      rate_reg <= wav_pkg::RATE_RESET;
      max_bytes_reg <= wav_pkg::MAX_BYTES_RESET;
      clear_parse();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (!empty && pop) begin
        if (expected_q.size() == 0) begin
          $error("result item popped with none expected");
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (out_item.item_kind !== want.item_kind) begin
            $error("item_kind: expected %0d, got %0d", want.item_kind,
                   out_item.item_kind);
            errs++;
          end
          if (out_item.sample_value !== want.sample_value) begin
            $error("sample_value: expected %0d, got %0d", want.sample_value,
                   out_item.sample_value);
            errs++;
          end
          if (out_item.status_code !== want.status_code) begin
            $error("status_code: expected %0d, got %0d", want.status_code,
                   out_item.status_code);
            errs++;
          end
          if (out_item.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end,
                   out_item.run_end);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      // Predict after the pop so that this cycle's results queue behind it.
      if (push && !full) parse_byte(in_item.data_byte, in_item.final_byte);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == wav_pkg::CFG_EXPECTED_RATE) rate_reg <= cfg_data;
        else max_bytes_reg <= cfg_data[26:0];
      end
    end
  end

endmodule

[sim/tb_wav_pcm16_stream_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WAV parser testbench
// Streams directed and random RIFF/WAVE files byte by byte into the parser
// under random back-pressure and register settings; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_wav_pcm16_stream_parser;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  wav_pkg::in_item_t  in_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  wav_pkg::out_item_t out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  int         pop_stall = 0;
  int         bytes_sent = 0;
  bit         no_gaps = 1'b0;
  logic [31:0] cur_rate = wav_pkg::RATE_RESET;
  logic [7:0] wav_q[$];

  always #6 clk = ~clk;

  wav_pcm16_stream_parser dut (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  wav_stream_checker checker_i (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wav_pcm16_stream_parser verification failed");
      $finish;
    end
  end

  // The consumer stalls at random; one assignment to pop per edge.
  always @(posedge clk) begin
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else begin
      pop <= 1'b1;
      if (!no_gaps) pop_stall <= idle_len();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    in_item <= '{data_byte: b, final_byte: fin};
    push <= 1'b1;
    do @(posedge clk); while (full);
    bytes_sent++;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_file();
    foreach (wav_q[i]) send_byte(wav_q[i], i == wav_q.size() - 1);
    wav_q.delete();
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == wav_pkg::CFG_EXPECTED_RATE) cur_rate = val;
  endtask

  function automatic void add_byte(input logic [7:0] v);
    wav_q = {wav_q, v};
  endfunction

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
  endtask

  task automatic put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) add_byte(t[8*i +: 8]);
  endtask

  task automatic put_random(input int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom));
  endtask

  task automatic put_chunk(input logic [31:0] t, input logic [31:0] len, input int body);
    put_tag(t);
    put_le(len, 4);
    put_random(body);
  endtask

  task automatic put_fmt(input logic [15:0] code, input logic [15:0] chans,
                         input logic [31:0] rate, input logic [15:0] bits,
                         input logic [31:0] len);
    put_tag(wav_pkg::TAG_FMT);
    put_le(len, 4);
    put_le(code, 2);
    put_le(chans, 2);
    put_le(rate, 4);
    put_random(6);
    put_le(bits, 2);
    put_random(int'(len) - 16 + int'(len[0]));
  endtask

  task automatic put_head();
    put_tag(wav_pkg::TAG_RIFF);
    put_random(4);
    put_tag(wav_pkg::TAG_WAVE);
  endtask

  // A well-formed file, with optional leading chunks and trailing bytes.
  task automatic put_good(input int data_len, input bit junk, input bit data_first,
                          input int tail);
    put_head();
    if (junk) put_chunk("LIST", 3, 4);
    if (data_first) put_chunk(wav_pkg::TAG_DATA, 2, 2);
    put_fmt(16'd1, 16'd1, cur_rate, 16'd16, $urandom_range(0, 3) == 0 ? 18 : 16);
    put_chunk(wav_pkg::TAG_DATA, data_len, data_len);
    put_random(tail);
  endtask

  initial begin
    int r;
    logic [7:0] keep;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed files.
    put_random(10); send_file();                                  // too short
    put_tag("RIFX"); put_random(40); send_file();                 // bad RIFF tag
    put_tag(wav_pkg::TAG_RIFF); put_random(4); put_tag("WAVX"); put_random(32);
    send_file();
    put_head(); put_fmt(1, 1, cur_rate, 16, 14); put_random(8); send_file();
    put_good(8, 1'b0, 1'b1, 0); send_file();                      // data before fmt
    put_head(); put_fmt(3, 1, cur_rate, 16, 16); put_chunk(wav_pkg::TAG_DATA, 8, 0);
    send_file();
    put_head(); put_fmt(1, 2, cur_rate, 16, 16); put_chunk(wav_pkg::TAG_DATA, 8, 0);
    send_file();
    put_head(); put_fmt(1, 1, cur_rate + 1, 16, 16); put_chunk(wav_pkg::TAG_DATA, 8, 0);
    send_file();
    put_head(); put_fmt(1, 1, cur_rate, 8, 16); put_chunk(wav_pkg::TAG_DATA, 8, 0);
    send_file();
    put_good(7, 1'b1, 1'b0, 3); send_file();                      // odd data length
    put_good(1, 1'b0, 1'b0, 6); send_file();
    put_head(); put_fmt(1, 1, cur_rate, 16, 16); put_tag(wav_pkg::TAG_DATA); put_le(4, 4);
    put_le(32'h7FFF8000, 4); put_random(4); send_file();          // sample extremes
    put_head(); put_random(9); send_file();                       // cut short after the header

    // Register settings: extremes, then random values.
    for (int p = 0; p < 6; p++) begin
      unique case (p)
        0: write_reg(wav_pkg::CFG_EXPECTED_RATE, 32'd0);
        1: write_reg(wav_pkg::CFG_EXPECTED_RATE, 32'hFFFFFFFF);
        2: write_reg(wav_pkg::CFG_MAX_FILE_BYTES, 32'd44);
        3: write_reg(wav_pkg::CFG_MAX_FILE_BYTES, 32'h07FFFFFF);
        4: write_reg(wav_pkg::CFG_EXPECTED_RATE, $urandom);
        default: begin
          write_reg(wav_pkg::CFG_MAX_FILE_BYTES, $urandom_range(44, 90));
          write_reg(wav_pkg::CFG_EXPECTED_RATE, wav_pkg::RATE_RESET);
        end
      endcase
      if (p == 2) begin
        // A 44-byte file sits exactly at the limit; one more byte is over it.
        put_head(); put_fmt(1, 1, cur_rate, 16, 16); put_chunk(wav_pkg::TAG_DATA, 0, 0);
        send_file();
        put_head(); put_fmt(1, 1, cur_rate, 16, 16); put_chunk(wav_pkg::TAG_DATA, 0, 0);
        put_random(1); send_file();
      end else if (p != 3) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 9);
        if (r < 7) begin
          put_good($urandom_range(2, 16), $urandom_range(0, 1), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 4));
          // Corrupt or truncate now and then.
          if (r == 6) begin
            keep = 8'($urandom);
            wav_q[$urandom_range(0, wav_q.size() - 1)] = keep;
          end
          if (r == 5) wav_q = wav_q[0 : $urandom_range(0, wav_q.size() - 1)];
        end else begin
          put_random($urandom_range(1, 60));
        end
        send_file();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("wav_pcm16_stream_parser verification clean");
    end else begin
      $display("wav_pcm16_stream_parser verification failed");
    end
    $finish;
  end

endmodule
